FILE: design/compacting_array_store_unit_assert.svh
// Assertion macros shared by the checker of the compacting array store unit.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef COMPACTING_ARRAY_STORE_UNIT_ASSERT_SVH
`define COMPACTING_ARRAY_STORE_UNIT_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define CASU_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("compacting array store: same-cycle check failed");

// The condition holds in the cycle after the trigger.
`define CASU_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("compacting array store: next-cycle check failed");

`endif

FILE: design/casu_pkg.sv
// Package for the compacting array store unit: the store capacity, command and
// status codes, the transaction structs and the controller state type. Depends on nothing.
package casu_pkg;

    localparam int CAPACITY = 16;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_DROP_LAST = 3'd1,
        CMD_REMOVE_EQ = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_READ_AT   = 3'd4
    } command_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [3:0]         index;
    } request_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [4:0]         entry_count;
        logic [2:0]         status;
    } result_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_SEARCH,
        FSM_SHIFT
    } fsm_state_t;

endpackage

FILE: design/compacting_array_store_unit.sv
// Compacting array store unit: a packed list of signed words in one
// synchronous memory with a live entry count. Depends on casu_pkg.
//
// A transaction is accepted when start is high and busy is low; exactly one
// result follows, shown on result for the single cycle in which done is high,
// and the receiver cannot stall it. Append, drop last and unknown commands
// return their result in the cycle after acceptance; a read passes through the
// read state first. Remove at index i walks the shift state, moving later
// entries down, and remove first match walks the search state until the match
// is found and then the shift state; a search that finds nothing ends in the
// search state. Both walks are set by the single read port of the entry
// memory, which delivers one entry per cycle.
module compacting_array_store_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  casu_pkg::request_t request,
    output logic              done,
    output casu_pkg::result_t  result
);
    import casu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;

    fsm_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      dst_reg, dst_next;
    logic               pend_reg, pend_next;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;
    logic signed [31:0] val_reg, val_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    logic               accept;
    logic               in_range;

    assign accept   = start && (state_reg == FSM_IDLE);
    assign in_range = XW'(request.index) < XW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            dst_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            dst_reg   <= dst_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        val_reg <= val_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        dst_next   = dst_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_waddr  = dst_reg[AW-1:0];
        mem_wdata  = rdata_reg;
        mem_re     = 1'b0;
        mem_raddr  = ptr_reg[AW-1:0];

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    val_next           = request.value;
                    res_next.read_data = '0;
                    res_next.status    = ST_DONE;
                    unique case (request.command)
                        CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = request.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DROP_LAST:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_REMOVE_EQ:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next       = 1'b1;
                                res_next.status = ST_NOMATCH;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                pend_next  = 1'b0;
                                state_next = FSM_SEARCH;
                            end
                        end
                        CMD_REMOVE_AT:
                        begin
                            if (!in_range)
                            begin
                                done_next       = 1'b1;
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                dst_next   = CW'(request.index);
                                ptr_next   = CW'(request.index) + 1'b1;
                                pend_next  = 1'b0;
                                state_next = FSM_SHIFT;
                            end
                        end
                        CMD_READ_AT:
                        begin
                            if (!in_range)
                            begin
                                done_next       = 1'b1;
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(request.index);
                                state_next = FSM_READ;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                    res_next.entry_count = 5'(count_next);
                end
            end
            FSM_READ:
            begin
                done_next          = 1'b1;
                res_next.read_data = rdata_reg;
                state_next         = FSM_IDLE;
            end
            FSM_SEARCH:
            begin
                if (pend_reg && (rdata_reg == val_reg))
                begin
                    ptr_next   = dst_reg + 1'b1;
                    pend_next  = 1'b0;
                    state_next = FSM_SHIFT;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    done_next            = 1'b1;
                    res_next.status      = ST_NOMATCH;
                    res_next.entry_count = 5'(count_reg);
                    state_next           = FSM_IDLE;
                end
            end
            FSM_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we   = 1'b1;
                    dst_next = dst_reg + 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && !(ptr_reg < count_reg))
                begin
                    count_next           = count_reg - 1'b1;
                    done_next            = 1'b1;
                    res_next.status      = ST_DONE;
                    res_next.entry_count = 5'(count_reg - 1'b1);
                    state_next           = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != FSM_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: design/casu_checker.sv
// Port-level checker for the compacting array store unit, bound to the unit
// module. Depends on casu_pkg and compacting_array_store_unit_assert.svh.
`include "compacting_array_store_unit_assert.svh"

module casu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input casu_pkg::result_t  result
);
    import casu_pkg::*;

    // Every accepted transaction either keeps the unit busy or completes at once.
    `CASU_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // A result only appears after an acceptance or after a busy cycle.
    `CASU_ASSERT_NEXT(a_no_spurious_done, clk, rst_n, !busy && !start, !done)

    `CASU_ASSERT_NOW(a_count_bound, clk, rst_n, done, 32'(result.entry_count) <= CAPACITY)

    // Failed commands never return data.
    `CASU_ASSERT_NOW(a_fail_no_data, clk, rst_n, done && (result.status != ST_DONE),
        result.read_data == '0)

endmodule

bind compacting_array_store_unit casu_checker u_casu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

FILE: tb/compacting_array_store_unit_checker.sv
// Checker for the compacting array store unit: keeps its own copy of the list,
// predicts the result of every accepted transaction and compares each result.
// Depends on casu_pkg.
`timescale 1ns / 100ps

module compacting_array_store_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  casu_pkg::request_t request,
    input  logic               done,
    input  casu_pkg::result_t  result,
    output int                 errors,
    output int                 pending
);
    import casu_pkg::*;

    logic [31:0] list_words [CAPACITY];
    int unsigned list_length;
    result_t     expected_results [$];
    result_t     oldest;

    initial
    begin
        errors = 0;
        pending = 0;
        list_length = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] compacting array store mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic void close_gap(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < list_length; k++)
            list_words[k] = list_words[k + 1];
        list_length--;
    endfunction

    function automatic result_t apply_command(input request_t req);
        result_t res;
        bit      hit;
        res.read_data = '0;
        res.status = ST_DONE;
        hit = 1'b0;
        case (req.command)
            CMD_APPEND:
                if (list_length >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    list_words[list_length] = req.value;
                    list_length++;
                end
            CMD_DROP_LAST:
                if (list_length == 0)
                    res.status = ST_EMPTY;
                else
                    list_length--;
            CMD_REMOVE_EQ:
            begin
                for (int unsigned pos = 0; pos < list_length && !hit; pos++)
                begin
                    if (list_words[pos] == req.value)
                    begin
                        close_gap(pos);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    res.status = ST_NOMATCH;
            end
            CMD_REMOVE_AT:
                if (req.index >= list_length)
                    res.status = ST_RANGE;
                else
                    close_gap(req.index);
            CMD_READ_AT:
                if (req.index >= list_length)
                    res.status = ST_RANGE;
                else
                    res.read_data = list_words[req.index];
            default:
                ;
        endcase
        res.entry_count = 5'(list_length);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no transaction outstanding");
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.read_data !== oldest.read_data)
                        report_mismatch($sformatf("read_data %0d, expected %0d",
                                                  result.read_data, oldest.read_data));
                    if (result.entry_count !== oldest.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  result.entry_count, oldest.entry_count));
                    if (result.status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  result.status, oldest.status));
                end
            end
            if (start && !busy)
                expected_results = {expected_results, apply_command(request)};
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/tb_compacting_array_store_unit.sv
// Top of the compacting array store unit testbench: drives directed and random
// command traffic and gives the verdict. Depends on casu_pkg, the unit and
// compacting_array_store_unit_checker.
`timescale 1ns / 100ps

module tb_compacting_array_store_unit;
    import casu_pkg::*;

    localparam int ITEM_TARGET = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 48;
    localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;
    localparam logic [2:0] LAST_UNUSED_CMD = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    request_t           request;
    result_t            result;
    int                 errors;
    int                 pending;
    int                 cycles;
    int                 issued;
    logic signed [31:0] value_pool [8];

    compacting_array_store_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    compacting_array_store_unit_checker store_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .errors(errors),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("compacting_array_store_unit test failed");
            $finish;
        end
    end

    function automatic request_t make_request(input logic [2:0] command,
                                              input logic signed [31:0] value,
                                              input logic [3:0] index);
        request_t req;
        req.command = command;
        req.value = value;
        req.index = index;
        return req;
    endfunction

    function automatic request_t pick_request(input traffic_mix_t mix);
        request_t req;
        int       roll;
        int       append_cut;
        int       drop_cut;
        int       match_cut;
        int       remove_cut;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                append_cut = 65; drop_cut = 72; match_cut = 80; remove_cut = 88;
            end
            MIX_DRAIN:
            begin
                append_cut = 20; drop_cut = 40; match_cut = 60; remove_cut = 78;
            end
            default:
            begin
                append_cut = 40; drop_cut = 50; match_cut = 65; remove_cut = 78;
            end
        endcase
        if (roll < append_cut)
            req.command = CMD_APPEND;
        else if (roll < drop_cut)
            req.command = CMD_DROP_LAST;
        else if (roll < match_cut)
            req.command = CMD_REMOVE_EQ;
        else if (roll < remove_cut)
            req.command = CMD_REMOVE_AT;
        else if (roll < 97)
            req.command = CMD_READ_AT;
        else
            req.command = 3'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
        if ($urandom_range(0, 3) == 0)
            req.value = $urandom;
        else
            req.value = value_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 1) == 0)
            req.index = 4'($urandom_range(0, 3));
        else
            req.index = 4'($urandom_range(0, 15));
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with start still high.
    task automatic send(input request_t req);
        request <= req;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued++;
        @(negedge clk);
    endtask

    task automatic hold_off(input int gap);
        start <= 1'b0;
        request <= make_request(3'($urandom), $urandom, 4'($urandom));
        repeat (gap)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        traffic_mix_t mix;
        int           phase_len;
        bit           no_gaps;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        issued = 0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        for (int k = 4; k < 8; k++)
            value_pool[k] = $urandom;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(make_request(CMD_DROP_LAST, 32'sd0, 4'd0));
        send(make_request(CMD_REMOVE_EQ, 32'sd0, 4'd0));
        send(make_request(CMD_REMOVE_AT, 32'sd0, 4'd0));
        send(make_request(CMD_READ_AT, 32'sd0, 4'd15));
        send(make_request(LAST_UNUSED_CMD, 32'sh7fff_ffff, 4'd15));
        for (int k = 0; k < CAPACITY; k++)
            send(make_request(CMD_APPEND, (k < 4) ? value_pool[k] : $signed($urandom),
                              4'(k)));
        send(make_request(CMD_APPEND, 32'sd5, 4'd0));
        send(make_request(CMD_READ_AT, 32'sd0, 4'd15));
        send(make_request(CMD_REMOVE_EQ, -32'sd1, 4'd0));
        send(make_request(CMD_REMOVE_AT, 32'sd0, 4'd0));
        wait_drained();

        while (issued < ITEM_TARGET)
        begin
            mix = traffic_mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(10, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && issued < ITEM_TARGET; n++)
            begin
                send(pick_request(mix));
                if (!no_gaps && $urandom_range(0, 4) == 0)
                    hold_off($urandom_range(1, 6));
            end
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("compacting_array_store_unit test passed");
        else
            $display("compacting_array_store_unit test failed");
        $finish;
    end

endmodule
